/* design/assert_macros.svh */
// Assertion helpers used by rau_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned OPERAND_WIDTH = 16;
    localparam int unsigned IN_W   = 16;
    localparam int unsigned NUM_W  = 33;
    localparam int unsigned DEN_W  = 32;
    localparam int unsigned MAG_W  = 2 * OPERAND_WIDTH + 1;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]             action;
        logic signed [IN_W-1:0] a_num;
        logic signed [IN_W-1:0] a_den;
        logic signed [IN_W-1:0] b_num;
        logic signed [IN_W-1:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    status;
    } out_item_t;

    // Request from front end to back end: magnitudes and class
    typedef struct packed {
        logic [MAG_W-1:0] nm;
        logic [MAG_W-1:0] dm;
        logic             neg;
        logic             zero_den;
        logic             zero_num;
    } job_t;

endpackage

/* design/rau_front.sv */
// ----------------------------------------------------------------------------
// rau_front
// Accepts requests, forms the raw fraction by cross-multiplication with
// one multiplier in states F_M0, F_M1 and F_M2, and classifies the result.
// ----------------------------------------------------------------------------
module rau_front
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t in_item,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job
);

    localparam int unsigned OW = OPERAND_WIDTH;
    localparam int unsigned PW = 2 * OW;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_M0   = 5'b00010,
        F_M1   = 5'b00100,
        F_M2   = 5'b01000,
        F_OUT  = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [1:0]             act_reg;
    logic signed [OW-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW:0]     p0_reg, p1_reg, p2_reg;
    logic signed [OW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW+1:0]   rn, rd;

    assign full = (state_reg != F_IDLE);

    // one shared multiplier, three products in turn
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        unique case (state_reg)
            F_M1:
            begin
                mul_a = ad_reg;
                mul_b = (act_reg == ACT_DIV) ? bn_reg : bd_reg;
            end
            F_M2:
            begin
                mul_a = (act_reg == ACT_MUL) ? an_reg : ad_reg;
                mul_b = bn_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (push) state_next = F_M0;
            F_M0:   state_next = F_M1;
            F_M1:   state_next = F_M2;
            F_M2:   state_next = F_OUT;
            F_OUT:  if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            act_reg <= in_item.action;
            an_reg  <= OW'(in_item.a_num);
            ad_reg  <= OW'(in_item.a_den);
            bn_reg  <= OW'(in_item.b_num);
            bd_reg  <= OW'(in_item.b_den);
        end
        if (state_reg == F_M0) p0_reg <= (PW+1)'(prod);
        if (state_reg == F_M1) p1_reg <= (PW+1)'(prod);
        if (state_reg == F_M2) p2_reg <= (PW+1)'(prod);
    end

    // p0 = an*bd, p1 = rd, p2 = second numerator term (whole numerator for multiply)
    always_comb
    begin
        rd = (PW+2)'(p1_reg);
        case (act_reg)
            ACT_ADD: rn = (PW+2)'(p0_reg) + (PW+2)'(p2_reg);
            ACT_SUB: rn = (PW+2)'(p0_reg) - (PW+2)'(p2_reg);
            ACT_MUL: rn = (PW+2)'(p2_reg);
            default: rn = (PW+2)'(p0_reg);
        endcase
    end

    assign job_valid    = (state_reg == F_OUT);
    assign job.neg      = rn[PW+1] ^ rd[PW+1];
    assign job.zero_den = (rd == '0);
    assign job.zero_num = (rn == '0);
    assign job.nm       = MAG_W'(rn[PW+1] ? -rn : rn);
    assign job.dm       = MAG_W'(rd[PW+1] ? -rd : rd);

endmodule

/* design/rau_queue.sv */
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module rau_queue
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr) wptr_reg <= ~wptr_reg;
            if (do_rd) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) mem_reg[wptr_reg] <= wr_data;
    end

endmodule

/* design/rau_back.sv */
// ----------------------------------------------------------------------------
// rau_back
// Binary GCD followed by two restoring divisions, one bit per cycle, and
// the output register; a zero numerator or denominator skips to the output.
// ----------------------------------------------------------------------------
module rau_back
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);
    `include "assert_macros.svh"

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_GCD  = 6'b000010,
        B_DIVN = 6'b000100,
        B_DIVD = 6'b001000,
        B_DONE = 6'b010000,
        B_HOLD = 6'b100000
    } bstate_t;

    localparam int unsigned CW = $clog2(MAG_W + 1);

    bstate_t          state_reg;
    logic [MAG_W-1:0] nm_reg, dm_reg, u_reg, v_reg, g_reg;
    logic [CW-1:0]    sh_reg, bit_reg;
    logic             neg_reg;
    logic [MAG_W-1:0] quo_reg, rem_reg, qn_reg;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W:0]   trial;
    logic [MAG_W-1:0] diff;
    logic             full_reg;

    assign job_ready = (state_reg == B_IDLE);
    assign empty     = !full_reg;
    assign dividend  = (state_reg == B_DIVN) ? nm_reg : dm_reg;
    assign trial     = {rem_reg, dividend[bit_reg[$clog2(MAG_W)-1:0]]};
    assign diff      = (u_reg > v_reg) ? u_reg - v_reg : v_reg - u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == B_DONE && (!full_reg || pop))
                full_reg <= 1'b1;
            else if (pop && full_reg)
                full_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE: if (job_valid)
                    state_reg <= (job.zero_den || job.zero_num) ? B_DONE : B_GCD;
                B_GCD:
                    if (u_reg == v_reg) state_reg <= B_DIVN;
                B_DIVN:
                    if (bit_reg == '0) state_reg <= B_DIVD;
                B_DIVD:
                    if (bit_reg == '0) state_reg <= B_DONE;
                B_DONE:
                    if (!full_reg || pop)
                        state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
                if (job_valid)
                begin
                    nm_reg  <= job.nm;
                    dm_reg  <= job.dm;
                    u_reg   <= job.nm;
                    v_reg   <= job.dm;
                    sh_reg  <= '0;
                    neg_reg <= job.neg;
                    quo_reg <= '0;
                    rem_reg <= '0;
                    if (job.zero_den)
                    begin
                        qn_reg  <= '0;
                        quo_reg <= '0;
                        neg_reg <= 1'b1;
                    end
                    else if (job.zero_num)
                    begin
                        qn_reg  <= '0;
                        quo_reg <= MAG_W'(1);
                        neg_reg <= 1'b0;
                    end
                end
            B_GCD:
            begin
                // Stein: strip common twos, then subtract
                if (u_reg == v_reg)
                begin
                    g_reg   <= u_reg << sh_reg;
                    bit_reg <= CW'(MAG_W - 1);
                    rem_reg <= '0;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg  <= u_reg >> 1;
                    v_reg  <= v_reg >> 1;
                    sh_reg <= sh_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else if (u_reg > v_reg)
                    u_reg <= diff;
                else
                    v_reg <= diff;
            end
            B_DIVN, B_DIVD:
            begin
                if (trial >= {1'b0, g_reg})
                begin
                    rem_reg <= MAG_W'(trial - {1'b0, g_reg});
                    quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= MAG_W'(trial);
                    quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
                end
                if (bit_reg == '0)
                begin
                    if (state_reg == B_DIVN)
                    begin
                        qn_reg  <= {quo_reg[MAG_W-2:0], trial >= {1'b0, g_reg}};
                        quo_reg <= '0;
                        rem_reg <= '0;
                        bit_reg <= CW'(MAG_W - 1);
                    end
                end
                else
                    bit_reg <= bit_reg - 1'b1;
            end
            B_DONE:
                if (!full_reg || pop)
                begin
                    out_item.res_num <= neg_reg && qn_reg == '0 && quo_reg == '0
                                      ? '0 : (neg_reg ? -qn_reg : qn_reg);
                    out_item.res_den <= DEN_W'(quo_reg);
                    out_item.status  <= neg_reg && qn_reg == '0 && quo_reg == '0;
                end
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_ready_idle, clk, rst_n, job_ready, state_reg == B_IDLE, "ready outside idle")
    `ASSERT_NEXT(a_gcd_nonzero, clk, rst_n, state_reg == B_GCD, u_reg != '0 && v_reg != '0,
                 "gcd operand hit zero")
    `ASSERT_IMPL(a_den_pos, clk, rst_n, !empty && !out_item.status, out_item.res_den != '0,
                 "zero denominator with good status")

endmodule

/* design/rational_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Adds, subtracts, multiplies or divides two fractions and reduces the
// result by the greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_item and raise push; the request is taken on
//   a clock edge with push high and full low.
//   Result side: while empty is low, out_item holds the oldest result; it is
//   taken on an edge with pop high.
//   Sequence: the front end forms three products on one multiplier
//   before the request enters the queue, then the back end runs a binary
//   GCD, two 33-bit one-bit-per-cycle divisions and the output register.
//   The back end sets the rate, taking a new request only when idle.
//   Zero numerator or zero denominator skips GCD and division in the back
//   end. A two-entry queue lets the front end take the next request
//   meanwhile. Reset empties the queue and the output register. If pop
//   stays low, the result is held, the back end, the queue and then the
//   front end fill, and full stays high.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    logic f_valid, f_ready, q_valid, q_ready;
    job_t f_job, q_job;

    rau_front u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rau_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    rau_back u_back (
        .clk, .rst_n,
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .empty, .pop, .out_item
    );

endmodule
